FILE: design/id3fw_pkg.sv
// Shared types, codes and character-class helpers for the ID3v2 frame walker.
`timescale 1ns / 1ps

package id3fw_pkg;

    localparam int MAX_RES = 3;   // most results one input byte can cause
    localparam int SIZE_W  = 28;  // syncsafe size width
    localparam int WALK_W  = 30;  // running walk total width

    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_EXT  = 3'd1,
        PH_FHDR = 3'd2,
        PH_BODY = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_BEGIN    = 3'd0,
        EV_CHAR     = 3'd1,
        EV_END      = 3'd2,
        EV_FOUND    = 3'd3,
        EV_NOTFOUND = 3'd4
    } event_t;

    typedef enum logic {
        CFG_MODE   = 1'b0,
        CFG_TARGET = 1'b1
    } cfg_index_t;

    // All results caused by one input byte, queued as one entry.
    typedef struct packed {
        logic [1:0]                 cnt;
        event_t [MAX_RES-1:0]       ev;
        logic [31:0]                id;
        logic [7:0]                 ch;
    } bundle_t;

    function automatic logic id_char_ok(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

endpackage

FILE: design/id3fw_front.sv
// Front end: accepts file bytes, tracks the tag walk and classifies each byte into results.
`timescale 1ns / 1ps

module id3fw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 start_of_file,
    input  logic                 mode,
    input  logic [31:0]          target_id,
    input  logic                 q_full,
    output logic                 q_push,
    output id3fw_pkg::bundle_t   q_data
);
    import id3fw_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   tag_size_reg, tag_size_next;
    logic [WALK_W-1:0]   walk_reg, walk_next;
    logic [SIZE_W-1:0]   fsize_reg, fsize_next;
    logic [31:0]         id_reg, id_next;
    logic                ext_reg, ext_next;
    logic                matched_reg, matched_next;

    logic                accept;
    bundle_t             bnd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && (bnd.cnt != 2'd0);
    assign q_data   = bnd;

    always_comb
    begin
        logic do_check;
        logic do_end;
        logic do_finish;
        logic [SIZE_W-1:0] cnt_inc;

        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        tag_size_next = tag_size_reg;
        walk_next     = walk_reg;
        fsize_next    = fsize_reg;
        id_next       = id_reg;
        ext_next      = ext_reg;
        matched_next  = matched_reg;
        do_check      = 1'b0;
        do_end        = 1'b0;
        do_finish     = 1'b0;
        bnd.cnt       = 2'd0;
        bnd.ch        = 8'd0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            bnd.ev[k] = EV_BEGIN;
        end

        if (start_of_file)
        begin
            phase_next    = PH_TAG;
            cnt_next      = '0;
            tag_size_next = '0;
            walk_next     = '0;
            fsize_next    = '0;
            id_next       = '0;
            ext_next      = 1'b0;
            matched_next  = 1'b0;
        end

        cnt_inc = cnt_next + SIZE_W'(1);

        case (phase_next)
            PH_TAG:
            begin
                if (cnt_next == SIZE_W'(5))
                    ext_next = |data_byte[7:6];
                else if (cnt_next >= SIZE_W'(6))
                    tag_size_next = {tag_size_next[SIZE_W-8:0], data_byte[6:0]};
                cnt_next = cnt_inc;
                if (cnt_inc >= SIZE_W'(10))
                begin
                    cnt_next = '0;
                    if (ext_next)
                        phase_next = PH_EXT;
                    else
                        do_check = 1'b1;
                end
            end
            PH_EXT:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= SIZE_W'(6))
                    do_check = 1'b1;
            end
            PH_FHDR:
            begin
                if (cnt_next == '0)
                begin
                    id_next    = {24'd0, data_byte};
                    fsize_next = '0;
                end
                else if (cnt_next < SIZE_W'(4))
                    id_next = {id_next[23:0], data_byte};
                else if (cnt_next < SIZE_W'(8))
                    fsize_next = {fsize_next[SIZE_W-8:0], data_byte[6:0]};
                cnt_next = cnt_inc;
                if (cnt_inc >= SIZE_W'(10))
                begin
                    cnt_next = '0;
                    if (!(id_char_ok(id_next[31:24]) && id_char_ok(id_next[23:16]) &&
                          id_char_ok(id_next[15:8])  && id_char_ok(id_next[7:0])))
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        walk_next    = walk_next + WALK_W'(10) + WALK_W'(fsize_next);
                        matched_next = mode && (id_next == target_id);
                        if (!mode || matched_next)
                        begin
                            bnd.ev[bnd.cnt] = EV_BEGIN;
                            bnd.cnt         = bnd.cnt + 2'd1;
                        end
                        if (fsize_next == '0)
                            do_finish = 1'b1;
                        else
                            phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if ((!mode || matched_next) && is_alnum(data_byte))
                begin
                    bnd.ev[bnd.cnt] = EV_CHAR;
                    bnd.ch          = data_byte;
                    bnd.cnt         = bnd.cnt + 2'd1;
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= fsize_next)
                begin
                    cnt_next  = '0;
                    do_finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Frame end: a match ends the walk; else it goes on unless the tag is used up.
        if (do_finish)
        begin
            if (matched_next)
            begin
                bnd.ev[bnd.cnt]        = EV_END;
                bnd.ev[bnd.cnt + 2'd1] = EV_FOUND;
                bnd.cnt                = bnd.cnt + 2'd2;
                phase_next             = PH_DONE;
                cnt_next               = '0;
            end
            else
            begin
                if (!mode)
                begin
                    bnd.ev[bnd.cnt] = EV_END;
                    bnd.cnt         = bnd.cnt + 2'd1;
                end
                do_check = 1'b1;
            end
        end

        if (do_check)
        begin
            if (walk_next >= WALK_W'(tag_size_next))
                do_end = 1'b1;
            else
            begin
                phase_next = PH_FHDR;
                cnt_next   = '0;
            end
        end

        if (do_end)
        begin
            phase_next = PH_DONE;
            cnt_next   = '0;
            if (mode)
            begin
                bnd.ev[bnd.cnt] = EV_NOTFOUND;
                bnd.cnt         = bnd.cnt + 2'd1;
            end
        end

        bnd.id = id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            cnt_reg      <= '0;
            tag_size_reg <= '0;
            walk_reg     <= '0;
            fsize_reg    <= '0;
            id_reg       <= '0;
            ext_reg      <= 1'b0;
            matched_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            tag_size_reg <= tag_size_next;
            walk_reg     <= walk_next;
            fsize_reg    <= fsize_next;
            id_reg       <= id_next;
            ext_reg      <= ext_next;
            matched_reg  <= matched_next;
        end
    end

endmodule

FILE: design/id3fw_queue.sv
// Small FIFO of result bundles between the front end and the output side.
`timescale 1ns / 1ps

module id3fw_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  id3fw_pkg::bundle_t   push_data,
    input  logic                 pop,
    output id3fw_pkg::bundle_t   head,
    output logic                 full,
    output logic                 empty
);
    import id3fw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t             store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/id3fw_back.sv
// Output side: unpacks queued bundles into single result items behind an output register.
`timescale 1ns / 1ps

module id3fw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  id3fw_pkg::bundle_t   head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           event_res,
    output logic [31:0]          frame_id,
    output logic [7:0]           char_out,
    output logic                 last
);
    import id3fw_pkg::*;

    logic          valid_reg;
    logic [1:0]    idx_reg, idx_next;
    event_t        event_reg;
    logic [31:0]   id_reg;
    logic [7:0]    char_reg;
    logic          last_reg;

    logic          load;
    event_t        ev_sel;
    logic          last_sel;

    assign load     = !q_empty && (!valid_reg || !out_stall);
    assign ev_sel   = head.ev[idx_reg];
    assign last_sel = (idx_reg == head.cnt - 2'd1);
    assign q_pop    = load && last_sel;
    assign idx_next = last_sel ? 2'd0 : idx_reg + 2'd1;

    assign out_valid = valid_reg;
    assign event_res = event_reg;
    assign frame_id  = id_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= ev_sel;
            id_reg    <= (ev_sel == EV_NOTFOUND) ? 32'd0 : head.id;
            char_reg  <= (ev_sel == EV_CHAR) ? head.ch : 8'd0;
            last_reg  <= last_sel;
        end
    end

endmodule

FILE: design/id3v2_frame_walker.sv
// Top level of the ID3v2 frame walker: configuration registers, front end, queue, output side.
`timescale 1ns / 1ps

// The block takes an ID3v2 tag one byte per item on the input channel (in_valid,
// in_stall, data_byte, start_of_file) and gives result items on the output channel
// (out_valid, out_stall, event_res, frame_id, char_out, last). A byte may cause zero
// to three results; last marks the final result of a byte.
// Configuration (mode, target_id) is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while the block is idle, which the block does not enforce.
// The front end takes one byte per cycle unless in_stall is high: it updates the walk
// state and packs all results of the byte into one queue entry. The output side sends
// one result per cycle from that queue, unless out_stall holds its output register,
// so a result passes through the queue entry and the registered output stage before
// out_valid rises for it. Sustained input rate is one byte per cycle as long as bytes
// cause on average no more than one result each and the receiver does not stall; a
// byte that causes three results holds the output side while it sends all three.
// When the receiver stalls, the output register holds its item, the queue fills, and
// once it is full the front end raises in_stall. Reset clears the walk state, the
// queue and the output stage, and sets both configuration registers to zero.

module id3v2_frame_walker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          start_of_file,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    event_res,
    output logic [31:0]   frame_id,
    output logic [7:0]    char_out,
    output logic          last
);
    import id3fw_pkg::*;

    logic          mode_reg;
    logic [31:0]   target_reg;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    bundle_t       q_wdata;
    bundle_t       q_head;

    // Configuration registers: plain write port, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            target_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_TARGET: target_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end parses the byte stream and classifies each byte.
    id3fw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .mode          (mode_reg),
        .target_id     (target_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    // Queue decouples parsing from result delivery.
    id3fw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Output side sends the queued results one item at a time.
    id3fw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .frame_id  (frame_id),
        .char_out  (char_out),
        .last      (last)
    );

    // The front end must never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("push into full result queue");

    // Retiring a queue entry means the item just loaded closes its byte.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> (out_valid && last))
        else $error("queue entry retired without a last item");

    // A not-found item carries no frame ID and no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_NOTFOUND) |-> (frame_id == 32'd0 && char_out == 8'd0))
        else $error("not-found item carries payload");

endmodule
